// ----- rtl/core/pnp_rtp_pkg.sv -----
package pnp_rtp_pkg;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LEN_LO  = 2'd1,
        PH_LEN_HI  = 2'd2,
        PH_PAYLOAD = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ROLE_SMALL   = 3'd0,
        ROLE_LARGE   = 3'd1,
        ROLE_LEN_LO  = 3'd2,
        ROLE_LEN_HI  = 3'd3,
        ROLE_PAYLOAD = 3'd4
    } t_role;

    localparam logic [7:0]  TYPE_END       = 8'd15;
    localparam logic [7:0]  TYPE_IDENT     = 8'd130;
    localparam logic [12:0] OFFSET_TOP     = 13'd8191;
    localparam int          OFFSET_OUT_W   = 13;
    localparam logic [7:0]  IDENT_MAX_RST  = 8'd79;

    typedef struct packed {
        logic [7:0]  byte_echo;
        t_role       byte_role;
        logic [7:0]  tag_type;
        logic [15:0] resource_length;
        logic [15:0] payload_index;
        logic [12:0] list_offset;
        logic        is_ident_char;
        logic        resource_last;
        logic        list_end;
        logic        overflow;
    } t_result;

endpackage

// ----- rtl/core/pnp_rtp_parse.sv -----
module pnp_rtp_parse #(
    parameter int LIST_BYTES = 8192
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_new_list,
    input  logic [7:0]           i_ident_max,
    output pnp_rtp_pkg::t_result o_result
);

    localparam int OW = $clog2(LIST_BYTES + 1);
    localparam int EW = (OW > pnp_rtp_pkg::OFFSET_OUT_W) ? OW : pnp_rtp_pkg::OFFSET_OUT_W;

    pnp_rtp_pkg::t_phase r_phase, n_phase, phase_eff;
    logic [7:0]    r_type, n_type;
    logic [15:0]   r_length, n_length;
    logic [15:0]   r_remaining, n_remaining;
    logic [OW-1:0] r_offset, n_offset;
    logic          r_ident_done, n_ident_done;
    logic [7:0]    r_ident_count, n_ident_count;
    logic          r_ovf, n_ovf;

    logic [OW-1:0] offs;
    logic [EW-1:0] offs_ext;
    logic          done_eff;
    logic [7:0]    count_eff;
    logic          ovf_eff;
    logic          ovf_hit;
    logic [15:0]   len_hi_val;
    logic [15:0]   rem_dec;
    logic          fin;
    logic [7:0]    type_now;
    logic          ident_ok;

    pnp_rtp_pkg::t_role role_out;
    logic [15:0]   rlen_out;
    logic [15:0]   pidx_out;

    // new_list clears tracking before this byte is handled
    assign phase_eff = i_new_list ? pnp_rtp_pkg::PH_HEADER : r_phase;
    assign offs      = i_new_list ? '0 : r_offset;
    assign done_eff  = i_new_list ? 1'b0 : r_ident_done;
    assign count_eff = i_new_list ? 8'd0 : r_ident_count;
    assign ovf_eff   = i_new_list ? 1'b0 : r_ovf;

    assign ovf_hit    = (offs >= OW'(LIST_BYTES));
    assign n_offset   = ovf_hit ? offs : offs + 1'b1;
    assign n_ovf      = ovf_eff | ovf_hit;
    assign offs_ext   = EW'(offs);
    assign len_hi_val = {i_data_byte, r_length[7:0]};
    assign rem_dec    = r_remaining - 16'd1;

    assign type_now = (phase_eff != pnp_rtp_pkg::PH_HEADER) ? r_type :
                      i_data_byte[7] ? {1'b1, i_data_byte[6:0]} :
                                       {4'd0, i_data_byte[6:3]};

    assign ident_ok = (phase_eff == pnp_rtp_pkg::PH_PAYLOAD)
                   && (r_type == pnp_rtp_pkg::TYPE_IDENT)
                   && !done_eff && (count_eff < i_ident_max);

    assign n_ident_done  = done_eff | (fin && (type_now == pnp_rtp_pkg::TYPE_IDENT));
    assign n_ident_count = count_eff + {7'd0, ident_ok};
    assign n_type        = type_now;

    always_comb begin
        fin = 1'b0;
        unique case (phase_eff)
            pnp_rtp_pkg::PH_HEADER:  fin = !i_data_byte[7] && (i_data_byte[2:0] == 3'd0);
            pnp_rtp_pkg::PH_LEN_LO:  fin = 1'b0;
            pnp_rtp_pkg::PH_LEN_HI:  fin = (len_hi_val == 16'd0);
            pnp_rtp_pkg::PH_PAYLOAD: fin = (rem_dec == 16'd0);
            default:                 fin = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_phase = phase_eff;
        unique case (phase_eff)
            pnp_rtp_pkg::PH_HEADER:
                n_phase = i_data_byte[7] ? pnp_rtp_pkg::PH_LEN_LO :
                          fin ? pnp_rtp_pkg::PH_HEADER : pnp_rtp_pkg::PH_PAYLOAD;
            pnp_rtp_pkg::PH_LEN_LO:
                n_phase = pnp_rtp_pkg::PH_LEN_HI;
            pnp_rtp_pkg::PH_LEN_HI:
                n_phase = fin ? pnp_rtp_pkg::PH_HEADER : pnp_rtp_pkg::PH_PAYLOAD;
            pnp_rtp_pkg::PH_PAYLOAD:
                n_phase = fin ? pnp_rtp_pkg::PH_HEADER : pnp_rtp_pkg::PH_PAYLOAD;
            default:
                n_phase = pnp_rtp_pkg::PH_HEADER;
        endcase
    end

    // outputs and datapath updates
    always_comb begin
        n_length    = r_length;
        n_remaining = r_remaining;
        role_out    = pnp_rtp_pkg::ROLE_SMALL;
        rlen_out    = 16'd0;
        pidx_out    = 16'd0;
        unique case (phase_eff)
            pnp_rtp_pkg::PH_HEADER: begin
                if (i_data_byte[7]) begin
                    role_out    = pnp_rtp_pkg::ROLE_LARGE;
                    n_length    = 16'd0;
                    n_remaining = 16'd0;
                end else begin
                    role_out    = pnp_rtp_pkg::ROLE_SMALL;
                    n_length    = {13'd0, i_data_byte[2:0]};
                    n_remaining = {13'd0, i_data_byte[2:0]};
                    rlen_out    = {13'd0, i_data_byte[2:0]};
                end
            end
            pnp_rtp_pkg::PH_LEN_LO: begin
                role_out = pnp_rtp_pkg::ROLE_LEN_LO;
                n_length = {8'd0, i_data_byte};
            end
            pnp_rtp_pkg::PH_LEN_HI: begin
                role_out    = pnp_rtp_pkg::ROLE_LEN_HI;
                n_length    = len_hi_val;
                n_remaining = len_hi_val;
                rlen_out    = len_hi_val;
            end
            pnp_rtp_pkg::PH_PAYLOAD: begin
                role_out    = pnp_rtp_pkg::ROLE_PAYLOAD;
                n_remaining = rem_dec;
                rlen_out    = r_length;
                pidx_out    = r_length - r_remaining;
            end
            default: begin
                role_out = pnp_rtp_pkg::ROLE_SMALL;
            end
        endcase
    end

    assign o_result.byte_echo       = i_data_byte;
    assign o_result.byte_role       = role_out;
    assign o_result.tag_type        = type_now;
    assign o_result.resource_length = rlen_out;
    assign o_result.payload_index   = pidx_out;
    assign o_result.list_offset     = (offs_ext > EW'(pnp_rtp_pkg::OFFSET_TOP)) ?
                                      pnp_rtp_pkg::OFFSET_TOP :
                                      offs_ext[pnp_rtp_pkg::OFFSET_OUT_W-1:0];
    assign o_result.is_ident_char   = ident_ok;
    assign o_result.resource_last   = fin;
    assign o_result.list_end        = fin && (type_now == pnp_rtp_pkg::TYPE_END);
    assign o_result.overflow        = n_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= pnp_rtp_pkg::PH_HEADER;
            r_type        <= 8'd0;
            r_length      <= 16'd0;
            r_remaining   <= 16'd0;
            r_offset      <= '0;
            r_ident_done  <= 1'b0;
            r_ident_count <= 8'd0;
            r_ovf         <= 1'b0;
        end else if (i_fire) begin
            r_phase       <= n_phase;
            r_type        <= n_type;
            r_length      <= n_length;
            r_remaining   <= n_remaining;
            r_offset      <= n_offset;
            r_ident_done  <= n_ident_done;
            r_ident_count <= n_ident_count;
            r_ovf         <= n_ovf;
        end
    end

endmodule

// ----- rtl/core/pnp_resource_tag_parser.sv -----
// Channel   Direction  Handshake                  Payload
// in        request    i_in_valid / o_in_ready    i_data_byte, i_new_list
// out       result     o_out_valid / i_out_ready  o_byte_echo .. o_overflow
// cfg       write      i_cfg_wr_en                i_cfg_wr_data (ident_max_chars)
//
// One byte per cycle sustained while the result side takes results. A request
// accepted into the input register is parsed from there and lands in the result
// register once that register is empty or being read; its result is offered there.
// Reset (synchronous, active low) puts the parser in header state, clears the
// offset, identifier tracking and overflow, and sets ident_max_chars to 79.
// A stalled result holds the result register; the input register takes a
// request when it is empty or when its own request moves on in the same cycle.
module pnp_resource_tag_parser #(
    parameter int LIST_BYTES = 8192
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_new_list,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_byte_echo,
    output logic [2:0]  o_byte_role,
    output logic [7:0]  o_tag_type,
    output logic [15:0] o_resource_length,
    output logic [15:0] o_payload_index,
    output logic [12:0] o_list_offset,
    output logic        o_is_ident_char,
    output logic        o_resource_last,
    output logic        o_list_end,
    output logic        o_overflow,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data
);

    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_in_new;
    logic [7:0]           r_ident_max;
    logic                 r_out_valid;
    pnp_rtp_pkg::t_result r_out;
    pnp_rtp_pkg::t_result parse_res;
    logic                 s2_fire;

    assign s2_fire    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || s2_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_data_byte;
            r_in_new  <= i_new_list;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ident_max <= pnp_rtp_pkg::IDENT_MAX_RST;
        end else if (i_cfg_wr_en) begin
            r_ident_max <= i_cfg_wr_data;
        end
    end

    pnp_rtp_parse #(
        .LIST_BYTES (LIST_BYTES)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (s2_fire),
        .i_data_byte (r_in_byte),
        .i_new_list  (r_in_new),
        .i_ident_max (r_ident_max),
        .o_result    (parse_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_fire) begin
            r_out <= parse_res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_byte_echo       = r_out.byte_echo;
    assign o_byte_role       = r_out.byte_role;
    assign o_tag_type        = r_out.tag_type;
    assign o_resource_length = r_out.resource_length;
    assign o_payload_index   = r_out.payload_index;
    assign o_list_offset     = r_out.list_offset;
    assign o_is_ident_char   = r_out.is_ident_char;
    assign o_resource_last   = r_out.resource_last;
    assign o_list_end        = r_out.list_end;
    assign o_overflow        = r_out.overflow;

endmodule

// ----- verif/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_BYTES  = 8192;
    localparam int CYCLE_LIMIT = 300000;

    localparam logic [6:0] IDENT_LARGE_TYPE = pnp_rtp_pkg::TYPE_IDENT[6:0];
    localparam logic [3:0] END_SMALL_TYPE   = pnp_rtp_pkg::TYPE_END[3:0];

    // Tracks the parse state of the byte stream and holds the reports
    // still owed by the block.
    class parse_tracker;
        pnp_rtp_pkg::t_result pending_reports[$];
        int unsigned          mismatches;
        logic [7:0]           ident_limit;
        pnp_rtp_pkg::t_phase  phase;
        logic [7:0]           cur_type;
        logic [15:0]          len_total;
        logic [15:0]          remaining;
        logic [13:0]          offset;
        logic                 ident_done;
        logic [7:0]           ident_count;
        logic                 ovf;

        function new();
            mismatches  = 0;
            ident_limit = pnp_rtp_pkg::IDENT_MAX_RST;
            phase       = pnp_rtp_pkg::PH_HEADER;
            cur_type    = '0;
            len_total   = '0;
            remaining   = '0;
            offset      = '0;
            ident_done  = 1'b0;
            ident_count = '0;
            ovf         = 1'b0;
        endfunction

        function int unsigned pending();
            return pending_reports.size();
        endfunction

        function void note_byte(logic [7:0] d, logic nl);
            pnp_rtp_pkg::t_result r;
            logic [13:0]          offs;
            logic                 done;
            r    = '0;
            done = 1'b0;
            if (nl) begin
                phase       = pnp_rtp_pkg::PH_HEADER;
                offset      = '0;
                ovf         = 1'b0;
                ident_done  = 1'b0;
                ident_count = '0;
            end
            offs = offset;
            // offset counter stops at the store size, the flag stays set
            if (offs >= LIST_BYTES) begin
                ovf = 1'b1;
            end else begin
                offset = offs + 14'd1;
            end
            r.byte_echo = d;
            case (phase)
                pnp_rtp_pkg::PH_LEN_LO: begin
                    r.byte_role = pnp_rtp_pkg::ROLE_LEN_LO;
                    len_total   = {8'h00, d};
                    phase       = pnp_rtp_pkg::PH_LEN_HI;
                end
                pnp_rtp_pkg::PH_LEN_HI: begin
                    r.byte_role       = pnp_rtp_pkg::ROLE_LEN_HI;
                    len_total         = {d, len_total[7:0]};
                    r.resource_length = len_total;
                    remaining         = len_total;
                    if (len_total == 16'd0) begin
                        done = 1'b1;
                    end else begin
                        phase = pnp_rtp_pkg::PH_PAYLOAD;
                    end
                end
                pnp_rtp_pkg::PH_PAYLOAD: begin
                    r.byte_role       = pnp_rtp_pkg::ROLE_PAYLOAD;
                    r.resource_length = len_total;
                    r.payload_index   = len_total - remaining;
                    if (cur_type == pnp_rtp_pkg::TYPE_IDENT && !ident_done &&
                        ident_count < ident_limit) begin
                        r.is_ident_char = 1'b1;
                        ident_count++;
                    end
                    remaining = remaining - 16'd1;
                    done      = (remaining == 16'd0);
                end
                default: begin
                    if (d[7]) begin
                        r.byte_role = pnp_rtp_pkg::ROLE_LARGE;
                        cur_type    = {1'b1, d[6:0]};
                        len_total   = '0;
                        remaining   = '0;
                        phase       = pnp_rtp_pkg::PH_LEN_LO;
                    end else begin
                        r.byte_role       = pnp_rtp_pkg::ROLE_SMALL;
                        cur_type          = {4'h0, d[6:3]};
                        len_total         = {13'h0, d[2:0]};
                        remaining         = len_total;
                        r.resource_length = len_total;
                        if (d[2:0] == 3'd0) begin
                            done = 1'b1;
                        end else begin
                            phase = pnp_rtp_pkg::PH_PAYLOAD;
                        end
                    end
                end
            endcase
            if (done) begin
                r.resource_last = 1'b1;
                r.list_end      = (cur_type == pnp_rtp_pkg::TYPE_END);
                if (cur_type == pnp_rtp_pkg::TYPE_IDENT) begin
                    ident_done = 1'b1;
                end
                phase = pnp_rtp_pkg::PH_HEADER;
            end
            r.tag_type    = cur_type;
            r.list_offset = (offs > pnp_rtp_pkg::OFFSET_TOP) ?
                            pnp_rtp_pkg::OFFSET_TOP : offs[12:0];
            r.overflow    = ovf;
            pending_reports.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_report(pnp_rtp_pkg::t_result got);
            pnp_rtp_pkg::t_result want;
            if (pending_reports.size() == 0) begin
                $error("byte_echo: expected none, got %0d", got.byte_echo);
                mismatches++;
                return;
            end
            want = pending_reports.pop_front();
            compare_field("byte_echo", want.byte_echo, got.byte_echo);
            compare_field("byte_role", want.byte_role, got.byte_role);
            compare_field("tag_type", want.tag_type, got.tag_type);
            compare_field("resource_length", want.resource_length, got.resource_length);
            compare_field("payload_index", want.payload_index, got.payload_index);
            compare_field("list_offset", want.list_offset, got.list_offset);
            compare_field("is_ident_char", want.is_ident_char, got.is_ident_char);
            compare_field("resource_last", want.resource_last, got.resource_last);
            compare_field("list_end", want.list_end, got.list_end);
            compare_field("overflow", want.overflow, got.overflow);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_data_byte;
    logic        i_new_list;
    logic        o_out_valid;
    logic        i_out_ready = 1'b1;
    logic [7:0]  o_byte_echo;
    logic [2:0]  o_byte_role;
    logic [7:0]  o_tag_type;
    logic [15:0] o_resource_length;
    logic [15:0] o_payload_index;
    logic [12:0] o_list_offset;
    logic        o_is_ident_char;
    logic        o_resource_last;
    logic        o_list_end;
    logic        o_overflow;
    logic        i_cfg_wr_en;
    logic [7:0]  i_cfg_wr_data;

    parse_tracker         tracker = new();
    pnp_rtp_pkg::t_result seen_report;
    logic [7:0]           list_buf[$];
    int unsigned          bytes_sent = 0;
    int unsigned          cycles = 0;
    int                   stall_left = 0;
    bit                   in_idle_on = 1'b0;
    bit                   out_idle_on = 1'b0;

    pnp_resource_tag_parser #(
        .LIST_BYTES (LIST_BYTES)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_data_byte       (i_data_byte),
        .i_new_list        (i_new_list),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_byte_echo       (o_byte_echo),
        .o_byte_role       (o_byte_role),
        .o_tag_type        (o_tag_type),
        .o_resource_length (o_resource_length),
        .o_payload_index   (o_payload_index),
        .o_list_offset     (o_list_offset),
        .o_is_ident_char   (o_is_ident_char),
        .o_resource_last   (o_resource_last),
        .o_list_end        (o_list_end),
        .o_overflow        (o_overflow),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side back-pressure: random stall bursts while out_idle_on is set
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (out_idle_on && $urandom_range(0, 5) == 0) begin
            stall_left  <= $urandom_range(0, 4);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen_report.byte_echo       = o_byte_echo;
            seen_report.byte_role       = pnp_rtp_pkg::t_role'(o_byte_role);
            seen_report.tag_type        = o_tag_type;
            seen_report.resource_length = o_resource_length;
            seen_report.payload_index   = o_payload_index;
            seen_report.list_offset     = o_list_offset;
            seen_report.is_ident_char   = o_is_ident_char;
            seen_report.resource_last   = o_resource_last;
            seen_report.list_end        = o_list_end;
            seen_report.overflow        = o_overflow;
            tracker.check_report(seen_report);
        end
    end

    task automatic send_byte(input logic [7:0] d, input logic nl);
        if (in_idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= d;
        i_new_list  <= nl;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        tracker.note_byte(d, nl);
        bytes_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_ident_limit(input logic [7:0] v);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        tracker.ident_limit = v;
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic void add_payload(input int n);
        repeat (n) list_buf.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void add_small(input logic [3:0] ty, input logic [2:0] n);
        list_buf.push_back({1'b0, ty, n});
        add_payload(int'(n));
    endfunction

    function automatic void add_large(input logic [6:0] ty, input logic [15:0] n);
        list_buf.push_back({1'b1, ty});
        list_buf.push_back(n[7:0]);
        list_buf.push_back(n[15:8]);
        add_payload(int'(n));
    endfunction

    // mostly short payloads, now and then a few hundred bytes
    function automatic logic [15:0] random_len();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return 16'd0;
        if (pick < 17) return 16'($urandom_range(1, 24));
        if (pick < 19) return 16'($urandom_range(25, 300));
        return 16'($urandom_range(256, 700));
    endfunction

    function automatic void build_list();
        int n_res;
        n_res = $urandom_range(1, 6);
        repeat (n_res) begin
            if ($urandom_range(0, 2) == 0) begin
                add_small(4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)));
            end else if ($urandom_range(0, 2) == 0) begin
                add_large(IDENT_LARGE_TYPE, random_len());
            end else begin
                add_large(7'($urandom_range(0, 127)), random_len());
            end
        end
        if ($urandom_range(0, 5) != 0) begin
            add_small(END_SMALL_TYPE, 3'($urandom_range(0, 7)));
        end
        // trailing resource after the end tag
        if ($urandom_range(0, 7) == 0) begin
            add_small(4'($urandom_range(0, 14)), 3'($urandom_range(0, 7)));
        end
    endfunction

    task automatic send_list();
        foreach (list_buf[i]) send_byte(list_buf[i], i == 0);
        list_buf.delete();
    endtask

    task automatic run_random(input int unsigned target, input bit allow_idle);
        int unsigned stop_at;
        int          mode;
        int          cut;
        stop_at = bytes_sent + target;
        while (bytes_sent < stop_at) begin
            in_idle_on  = allow_idle && ($urandom_range(0, 3) != 0);
            out_idle_on = allow_idle && ($urandom_range(0, 3) != 0);
            mode = $urandom_range(0, 9);
            if (mode == 0) begin
                repeat ($urandom_range(1, 12)) begin
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                end
            end else begin
                build_list();
                // broken list: the next request may restart the parser mid-resource
                if (mode == 1) begin
                    cut = $urandom_range(1, list_buf.size());
                    while (list_buf.size() > cut) void'(list_buf.pop_back());
                end
                send_list();
            end
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_data_byte   <= '0;
        i_new_list    <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty small tag, full small tag, identifier string, empty large type 15,
        // end tags with and without payload, then bytes past the list end
        list_buf = '{8'h00, 8'h0F, 8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F,
                     8'h82, 8'h03, 8'h00, 8'h41, 8'h42, 8'h43,
                     8'h8F, 8'h00, 8'h00,
                     8'h79, 8'hFF,
                     8'h78, 8'hFF, 8'h00, 8'h00};
        send_list();

        write_ident_limit(8'd0);
        run_random(250, 1'b1);
        write_ident_limit(8'd255);
        run_random(250, 1'b1);
        write_ident_limit(8'd1);
        run_random(200, 1'b1);
        write_ident_limit(8'($urandom_range(2, 254)));
        run_random(250, 1'b1);

        write_ident_limit(8'd3);
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        run_random(300, 1'b0);

        // identifier longer than the limit, then a second one that stays unflagged
        add_large(IDENT_LARGE_TYPE, 16'd40);
        add_large(IDENT_LARGE_TYPE, 16'd5);
        add_small(END_SMALL_TYPE, 3'd0);
        add_small(4'd3, 3'd2);
        add_large(7'h7F, 16'd4);
        send_list();
        build_list();
        send_list();

        drain();
        repeat (8) @(posedge i_clk);
        if (tracker.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/pnp_rtp_pkg.sv
rtl/core/pnp_rtp_parse.sv
rtl/core/pnp_resource_tag_parser.sv
verif/tb.sv
